// ----- hw/rtl/vvfe_pkg.sv -----
// shared constants, types and helper functions of the voxel face emitter
`default_nettype none

package vvfe_pkg;

  // world size in voxels along each axis
  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 16;
  localparam int SIZE_Z = 16;

  localparam int CoordW   = 4;
  localparam int NumRows  = SIZE_X * SIZE_Y;
  localparam int RowAddrW = $clog2(NumRows);
  localparam int RowW     = SIZE_Z;
  localparam int ZIdxW    = $clog2(SIZE_Z);
  localparam int NumFaces = 6;
  localparam int FaceW    = 3;
  localparam int DataW    = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // face codes, also bit positions in a visibility mask
  localparam int FACE_XM = 0;
  localparam int FACE_XP = 1;
  localparam int FACE_YM = 2;
  localparam int FACE_YP = 3;
  localparam int FACE_ZM = 4;
  localparam int FACE_ZP = 5;

  // memory access step of the item in the issue stage
  typedef enum logic [2:0] {
    STEP_ROW,
    STEP_XM,
    STEP_XP,
    STEP_YM,
    STEP_YP,
    STEP_WB
  } step_e;

  // culled voxel waiting for the emitter
  typedef struct packed {
    logic                valid;
    logic [NumFaces-1:0] vis;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [CoordW-1:0]   z;
  } face_res_t;

  function automatic logic in_world(input logic [CoordW-1:0] x,
                                    input logic [CoordW-1:0] y,
                                    input logic [CoordW-1:0] z);
    return (int'(x) < SIZE_X) && (int'(y) < SIZE_Y) && (int'(z) < SIZE_Z);
  endfunction

  // one memory row holds all z of one (x, y) column
  function automatic logic [RowAddrW-1:0] row_addr(input logic [CoordW-1:0] x,
                                                   input logic [CoordW-1:0] y);
    logic [31:0] a;
    a = 32'(x) * 32'(SIZE_Y) + 32'(y);
    return a[RowAddrW-1:0];
  endfunction

  function automatic logic [FaceW-1:0] first_face(input logic [NumFaces-1:0] mask);
    logic [FaceW-1:0] f;
    f = '0;
    for (int i = NumFaces - 1; i >= 0; i--) begin
      if (mask[i]) f = FaceW'(i);
    end
    return f;
  endfunction

  function automatic logic [NumFaces-1:0] drop_lowest(input logic [NumFaces-1:0] mask);
    return mask & (mask - NumFaces'(1));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/voxel_visible_face_emitter.sv -----
// top level of the voxel visible face emitter
//
// Keeps a 16 x 16 x 16 occupancy map in one block ram of 256 rows, each row
// holding the 16 z bits of one (x, y) column. A write item (tuser = 0) does a
// read-modify-write of its row: a row read step, then a write-back step. A query
// item (tuser = 1) reads its own row and the four side rows (x-1, x+1, y-1,
// y+1) through the single read port, one row a cycle; the z neighbors come from
// its own row. A query issues five row reads, and the next query may not start
// until the last row has come back and the result slot is free or being taken.
// The face items of a voxel then leave one per cycle from the output register
// while tready is high, up to six, while later items are already being read.
// After reset the ram is swept to zero, one row a cycle, over all 256 rows;
// tready stays low during that sweep.
`default_nettype none

module voxel_visible_face_emitter import vvfe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x[3:0], pos_y[7:4], pos_z[11:8], occupied[12], zero pad[15:13]
  input  wire logic [DataW-1:0] s_axis_tdata,
  // command[0]
  input  wire logic             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // face[2:0], face_x[6:3], face_y[10:7], face_z[14:11], zero pad[15]
  output logic      [DataW-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  // ---------------------------------------------------------------------------
  // issue stage: the item currently driving the memory port
  // ---------------------------------------------------------------------------
  logic              cur_valid_q;
  logic              cur_cmd_q;
  logic [CoordW-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic              cur_occ_q;
  step_e             step_q, step_d;

  // sweep that zeroes the ram after reset
  logic                clr_active_q;
  logic [RowAddrW-1:0] clr_addr_q;

  // read tag: which query row comes back from the ram this cycle
  logic  rtag_valid_q;
  step_e rtag_step_q;

  // collection of the query whose rows are returning
  logic                col_occ_q, col_occ_d;
  logic                col_in_q;
  logic [NumFaces-1:0] col_vis_q, col_vis_d;
  logic [CoordW-1:0]   col_x_q, col_y_q, col_z_q;

  face_res_t res_q, res_d;
  logic      res_take;

  // ram port
  logic                ram_we;
  logic [RowAddrW-1:0] ram_waddr;
  logic [RowW-1:0]     ram_wdata;
  logic [RowAddrW-1:0] ram_raddr;
  logic [RowW-1:0]     ram_rdata;

  logic go, last_step, cur_done, accept, is_query, query_start;
  logic [CoordW-1:0] rd_x, rd_y;

  assign is_query    = (cur_cmd_q == CMD_QUERY);
  // a new query waits until the previous one has left the collection regs and the result slot is free or being taken
  assign query_start = is_query && (step_q == STEP_ROW);
  assign go          = cur_valid_q &&
                       !(query_start && (rtag_valid_q || (res_q.valid && !res_take)));
  assign last_step   = (step_q == STEP_YP) || (step_q == STEP_WB);
  assign cur_done    = go && last_step;

  assign s_axis_tready = !clr_active_q && (!cur_valid_q || cur_done);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // next step of the sequencer
  always_comb begin
    step_d = step_q;
    if (go) begin
      case (step_q)
        STEP_ROW: step_d = is_query ? STEP_XM : STEP_WB;
        STEP_XM:  step_d = STEP_XP;
        STEP_XP:  step_d = STEP_YM;
        STEP_YM:  step_d = STEP_YP;
        STEP_YP:  step_d = STEP_ROW;
        STEP_WB:  step_d = STEP_ROW;
        default:  step_d = STEP_ROW;
      endcase
    end
  end

  // memory addresses and write data per step; a neighbor across the world
  // edge reads the own row instead, its bit is ignored later
  always_comb begin
    logic [RowW-1:0] wb_row;
    rd_x = cur_x_q;
    rd_y = cur_y_q;
    case (step_q)
      STEP_XM: rd_x = (cur_x_q == '0) ? cur_x_q : cur_x_q - CoordW'(1);
      STEP_XP: rd_x = (cur_x_q == CoordW'(SIZE_X - 1)) ? cur_x_q : cur_x_q + CoordW'(1);
      STEP_YM: rd_y = (cur_y_q == '0) ? cur_y_q : cur_y_q - CoordW'(1);
      STEP_YP: rd_y = (cur_y_q == CoordW'(SIZE_Y - 1)) ? cur_y_q : cur_y_q + CoordW'(1);
      default: begin
        rd_x = cur_x_q;
        rd_y = cur_y_q;
      end
    endcase
    ram_raddr = row_addr(rd_x, rd_y);

    wb_row = ram_rdata;
    wb_row[cur_z_q[ZIdxW-1:0]] = cur_occ_q;

    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = go && (step_q == STEP_WB) && in_world(cur_x_q, cur_y_q, cur_z_q);
      ram_waddr = row_addr(cur_x_q, cur_y_q);
      ram_wdata = wb_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      step_q       <= STEP_ROW;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      rtag_valid_q <= 1'b0;
      rtag_step_q  <= STEP_ROW;
    end else begin
      if (accept) begin
        cur_valid_q <= 1'b1;
      end else if (cur_done) begin
        cur_valid_q <= 1'b0;
      end
      step_q <= step_d;
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + RowAddrW'(1);
        if (clr_addr_q == RowAddrW'(NumRows - 1)) clr_active_q <= 1'b0;
      end
      rtag_valid_q <= go && is_query;
      rtag_step_q  <= step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_cmd_q <= s_axis_tuser;
      cur_x_q   <= s_axis_tdata[3:0];
      cur_y_q   <= s_axis_tdata[7:4];
      cur_z_q   <= s_axis_tdata[11:8];
      cur_occ_q <= s_axis_tdata[12];
    end
    if (go && query_start) begin
      col_x_q  <= cur_x_q;
      col_y_q  <= cur_y_q;
      col_z_q  <= cur_z_q;
      col_in_q <= in_world(cur_x_q, cur_y_q, cur_z_q);
    end
    col_occ_q <= col_occ_d;
    col_vis_q <= col_vis_d;
  end

  // ---------------------------------------------------------------------------
  // collection: one returning row a cycle turns into visibility bits
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [ZIdxW-1:0] zc, zm, zp;
    zc = col_z_q[ZIdxW-1:0];
    zm = (col_z_q == '0) ? zc : zc - ZIdxW'(1);
    zp = (col_z_q == CoordW'(SIZE_Z - 1)) ? zc : zc + ZIdxW'(1);

    col_occ_d = col_occ_q;
    col_vis_d = col_vis_q;
    res_d     = res_q;
    if (res_take) res_d.valid = 1'b0;

    if (rtag_valid_q) begin
      case (rtag_step_q)
        STEP_ROW: begin
          col_occ_d          = ram_rdata[zc];
          col_vis_d[FACE_ZM] = (col_z_q == '0) || !ram_rdata[zm];
          col_vis_d[FACE_ZP] = (col_z_q == CoordW'(SIZE_Z - 1)) || !ram_rdata[zp];
        end
        STEP_XM: col_vis_d[FACE_XM] = (col_x_q == '0) || !ram_rdata[zc];
        STEP_XP: col_vis_d[FACE_XP] = (col_x_q == CoordW'(SIZE_X - 1)) || !ram_rdata[zc];
        STEP_YM: col_vis_d[FACE_YM] = (col_y_q == '0) || !ram_rdata[zc];
        STEP_YP: begin
          col_vis_d[FACE_YP] = (col_y_q == CoordW'(SIZE_Y - 1)) || !ram_rdata[zc];
          // empty, outside or fully enclosed voxels give nothing
          res_d.valid = col_occ_q && col_in_q && (col_vis_d != '0);
          res_d.vis   = col_vis_d;
          res_d.x     = col_x_q;
          res_d.y     = col_y_q;
          res_d.z     = col_z_q;
        end
        default: col_vis_d = col_vis_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  vvfe_ram #(
    .Width (RowW),
    .Depth (NumRows)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vvfe_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res_q),
    .res_take_o    (res_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // no item may enter while the ram is being swept
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s_axis_tready)
    else $error("item accepted during ram clear");

  // the last row of a query never lands on an occupied result slot
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rtag_valid_q && (rtag_step_q == STEP_YP)) |-> (!res_q.valid || res_take))
    else $error("query result overwrites a pending voxel");

  a_res_has_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid |-> (res_q.vis != '0))
    else $error("pending voxel without a visible face");

  // a write-back always directly follows the read of its own row
  a_wb_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && (step_q == STEP_WB)) |-> $past(go && (step_q == STEP_ROW) && !is_query))
    else $error("write-back without its row read");

endmodule

`default_nettype wire

// ----- hw/rtl/vvfe_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module vvfe_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vvfe_emitter.sv -----
// output stage: walks a visibility mask and sends one face item per cycle while m_axis_tready is high
`default_nettype none

module vvfe_emitter import vvfe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire face_res_t        res_i,
  output logic                  res_take_o,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // face[2:0], face_x[6:3], face_y[10:7], face_z[14:11], zero pad[15]
  output logic      [DataW-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic                out_valid_q, out_valid_d;
  logic                out_last_q, out_last_d;
  logic [FaceW-1:0]    out_face_q, out_face_d;
  logic [CoordW-1:0]   out_x_q, out_x_d;
  logic [CoordW-1:0]   out_y_q, out_y_d;
  logic [CoordW-1:0]   out_z_q, out_z_d;
  logic [NumFaces-1:0] rem_q, rem_d;
  logic                out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_face_d  = out_face_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    rem_d       = rem_q;
    res_take_o  = 1'b0;
    if (out_free) begin
      if (rem_q != '0) begin
        out_valid_d = 1'b1;
        out_face_d  = first_face(rem_q);
        rem_d       = drop_lowest(rem_q);
        out_last_d  = (drop_lowest(rem_q) == '0);
      end else if (res_i.valid) begin
        res_take_o  = 1'b1;
        out_valid_d = 1'b1;
        out_face_d  = first_face(res_i.vis);
        rem_d       = drop_lowest(res_i.vis);
        out_last_d  = (drop_lowest(res_i.vis) == '0);
        out_x_d     = res_i.x;
        out_y_d     = res_i.y;
        out_z_d     = res_i.z;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_last_q <= out_last_d;
    out_face_q <= out_face_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_z_q    <= out_z_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_z_q, out_y_q, out_x_q, out_face_q};

  // faces still pending always sit behind a shown, non-final face
  a_rem_behind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> (out_valid_q && !out_last_q))
    else $error("pending faces without a shown face");

  a_not_last_has_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (rem_q != '0))
    else $error("non-final face with nothing left to send");

  a_take_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take_o |-> (rem_q == '0))
    else $error("new voxel taken while faces still pending");

endmodule

`default_nettype wire

// ----- test/voxel_visible_face_emitter_tb.sv -----
// testbench of the voxel visible face emitter: directed scenes, then random scenes
`timescale 1ns / 1ps

module voxel_visible_face_emitter_tb;
  import vvfe_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 24;
  localparam int RandomItems = 480;

  // one face item as it should leave the block
  typedef struct {
    logic [FaceW-1:0]  face;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              last;
  } face_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic             s_axis_tuser = CMD_WRITE;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  // occupancy as this bench sees it, empty after reset
  bit occ_map [SIZE_X][SIZE_Y][SIZE_Z];
  face_item_t face_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int rx_phase = 0;
  logic [7:0] rx_mask = 8'hFF;

  voxel_visible_face_emitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d face items outstanding", $time, face_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // update the occupancy map and queue the visible faces of a query
  function automatic void apply_to_world(input logic cmd, input logic [CoordW-1:0] px,
                                         input logic [CoordW-1:0] py,
                                         input logic [CoordW-1:0] pz, input logic occ);
    int x;
    int y;
    int z;
    logic [NumFaces-1:0] vis;
    face_item_t item;
    int count;
    x = px;
    y = py;
    z = pz;
    // 4-bit coordinates never leave a 16 wide world
    if (cmd == CMD_WRITE) begin
      occ_map[x][y][z] = occ;
      return;
    end
    if (!occ_map[x][y][z]) return;
    vis[FACE_XM] = (x == 0) || !occ_map[x-1][y][z];
    vis[FACE_XP] = (x == SIZE_X - 1) || !occ_map[x+1][y][z];
    vis[FACE_YM] = (y == 0) || !occ_map[x][y-1][z];
    vis[FACE_YP] = (y == SIZE_Y - 1) || !occ_map[x][y+1][z];
    vis[FACE_ZM] = (z == 0) || !occ_map[x][y][z-1];
    vis[FACE_ZP] = (z == SIZE_Z - 1) || !occ_map[x][y][z+1];
    count = 0;
    for (int f = 0; f < NumFaces; f++) begin
      if (vis[f]) begin
        item.face = FaceW'(f);
        item.x = px;
        item.y = py;
        item.z = pz;
        item.last = 1'b0;
        face_q.push_back(item);
        count++;
      end
    end
    // a fully enclosed voxel leaves nothing to flag
    if (count > 0) face_q[face_q.size()-1].last = 1'b1;
  endfunction

  // offer one item, wait for its handshake, then maybe pause between bursts
  task automatic send_item(input logic cmd, input logic [CoordW-1:0] px,
                           input logic [CoordW-1:0] py, input logic [CoordW-1:0] pz,
                           input logic occ);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, occ, pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_to_world(cmd, px, py, pz, occ);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(30, 60);
      else burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // receiver stalls on a rotating mask, reloaded now and then
  always @(posedge clk_i) begin
    rx_phase++;
    if (rx_phase % 40 == 0) begin
      rx_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      if (rx_mask == 8'h00) rx_mask = 8'h01;
    end
    m_axis_tready <= rx_mask[0];
    rx_mask = {rx_mask[0], rx_mask[7:1]};
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // compare each face item with the oldest one queued
  always @(posedge clk_i) begin : check_faces
    face_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (face_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected face item, expected none, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = face_q.pop_front();
        check_field("face", want.face, m_axis_tdata[2:0]);
        check_field("face_x", want.x, m_axis_tdata[6:3]);
        check_field("face_y", want.y, m_axis_tdata[10:7]);
        check_field("face_z", want.z, m_axis_tdata[14:11]);
        check_field("last_face", want.last, m_axis_tlast);
      end
    end
  end

  // nothing is occupied yet, so queries stay silent
  task automatic test_empty_world();
    send_item(CMD_QUERY, 4'd0, 4'd0, 4'd0, 1'b1);
    send_item(CMD_QUERY, 4'd15, 4'd15, 4'd15, 1'b0);
  endtask

  // single voxels on opposite corners show all six faces, cleared ones none
  task automatic test_lone_voxels();
    send_item(CMD_WRITE, 4'd0, 4'd0, 4'd0, 1'b1);
    send_item(CMD_QUERY, 4'd0, 4'd0, 4'd0, 1'b0);
    send_item(CMD_WRITE, 4'd15, 4'd15, 4'd15, 1'b1);
    send_item(CMD_QUERY, 4'd15, 4'd15, 4'd15, 1'b1);
    send_item(CMD_WRITE, 4'd0, 4'd0, 4'd0, 1'b0);
    send_item(CMD_QUERY, 4'd0, 4'd0, 4'd0, 1'b1);
  endtask

  // a voxel boxed in on all sides, then opened on its front
  task automatic test_enclosed_voxel();
    send_item(CMD_WRITE, 4'd7, 4'd7, 4'd7, 1'b1);
    send_item(CMD_WRITE, 4'd6, 4'd7, 4'd7, 1'b1);
    send_item(CMD_WRITE, 4'd8, 4'd7, 4'd7, 1'b1);
    send_item(CMD_WRITE, 4'd7, 4'd6, 4'd7, 1'b1);
    send_item(CMD_WRITE, 4'd7, 4'd8, 4'd7, 1'b1);
    send_item(CMD_WRITE, 4'd7, 4'd7, 4'd6, 1'b1);
    send_item(CMD_WRITE, 4'd7, 4'd7, 4'd8, 1'b1);
    send_item(CMD_QUERY, 4'd7, 4'd7, 4'd7, 1'b0);
    send_item(CMD_QUERY, 4'd8, 4'd7, 4'd7, 1'b0);
    send_item(CMD_WRITE, 4'd7, 4'd7, 4'd8, 1'b0);
    send_item(CMD_QUERY, 4'd7, 4'd7, 4'd7, 1'b0);
  endtask

  // dense little scenes in a 4x4x4 box that moves around, with some noise
  task automatic test_random_scenes();
    int ox;
    int oy;
    int oz;
    logic cmd;
    logic occ;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [CoordW-1:0] pz;
    ox = 0;
    oy = 0;
    oz = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 60 == 0) begin
        // pull the box onto the world edges often
        case ($urandom_range(0, 3))
          0: ox = 0;
          1: ox = SIZE_X - 4;
          default: ox = $urandom_range(0, SIZE_X - 4);
        endcase
        case ($urandom_range(0, 3))
          0: oy = 0;
          1: oy = SIZE_Y - 4;
          default: oy = $urandom_range(0, SIZE_Y - 4);
        endcase
        case ($urandom_range(0, 3))
          0: oz = 0;
          1: oz = SIZE_Z - 4;
          default: oz = $urandom_range(0, SIZE_Z - 4);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        cmd = 1'($urandom);
        occ = 1'($urandom);
        px = CoordW'($urandom);
        py = CoordW'($urandom);
        pz = CoordW'($urandom);
      end else begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_QUERY;
        occ = ($urandom_range(0, 3) != 0);
        px = CoordW'(ox + $urandom_range(0, 3));
        py = CoordW'(oy + $urandom_range(0, 3));
        pz = CoordW'(oz + $urandom_range(0, 3));
      end
      send_item(cmd, px, py, pz, occ);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_world();
    test_lone_voxels();
    test_enclosed_voxel();
    test_random_scenes();
    s_axis_tvalid <= 1'b0;
    while (face_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- voxel_visible_face_emitter.f -----
hw/rtl/vvfe_pkg.sv
hw/rtl/vvfe_ram.sv
hw/rtl/vvfe_emitter.sv
hw/rtl/voxel_visible_face_emitter.sv
test/voxel_visible_face_emitter_tb.sv
